// File: src/event_trace_recorder_with_stats_assert.svh
// Assertion macros for the event trace recorder.
// Used by the top level; the macros expect clk and rst in scope.
`ifndef EVENT_TRACE_RECORDER_WITH_STATS_ASSERT_SVH
`define EVENT_TRACE_RECORDER_WITH_STATS_ASSERT_SVH

// Same-cycle implication, masked while in reset
`define ETR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while in reset
`define ETR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/etr_pkg.sv
// Shared types and constants for the event trace recorder.
// No dependencies; used by every other file of the block but the assertion header.
`default_nettype none

package etr_pkg;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CLS_W   = 6;
  localparam int unsigned TIME_W  = 63;
  localparam int unsigned FRAME_W = 64;
  localparam int unsigned ARG_W   = 64;
  localparam int unsigned COUNT_W = 64;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam int unsigned RECENT_DEPTH_DEF  = 4096;
  localparam int unsigned SLOW_DEPTH_DEF    = 256;
  localparam int unsigned EVENT_CLASSES_DEF = 64;

  localparam logic [CLS_W-1:0]  PRESENT_CLASS     = 6'd34;
  localparam logic [CLS_W-1:0]  PRESENT_GAP_CLASS = 6'd35;
  localparam logic [ARG_W-1:0]  S_OK              = '0;
  localparam logic [TIME_W-1:0] THRESHOLD_RESET   = 63'd500000;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TRACE_ENABLE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TIME_ORIGIN    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_THRESHOLD = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_RECORD, KIND_MARK, KIND_SET_FRAME, KIND_PRESENT
  } kind_t;

  typedef struct packed {
    logic              enable;
    logic [TIME_W-1:0] origin;
    logic [TIME_W-1:0] threshold;
  } cfg_t;

  // One checked event on its way to the statistics stage
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [CLS_W-1:0]   cls;
    logic [TIME_W-1:0]  start;
    logic [TIME_W-1:0]  dur;
    logic [FRAME_W-1:0] frame;
    logic [ARG_W-1:0]   a;
    logic [ARG_W-1:0]   b;
  } offer_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  sum;
    logic [TIME_W-1:0]  peak;
    logic [TIME_W-1:0]  peak_start;
    logic [COUNT_W-1:0] slow_count;
  } stats_t;

  typedef struct packed {
    logic [CLS_W-1:0]   cls;
    logic [TIME_W-1:0]  start;
    logic [TIME_W-1:0]  len;
    logic [FRAME_W-1:0] frame;
    logic [ARG_W-1:0]   a;
    logic [ARG_W-1:0]   b;
  } ring_entry_t;

  typedef struct packed {
    logic        recent_we;
    logic        slow_we;
    ring_entry_t entry;
  } ring_wr_t;

endpackage

`default_nettype wire

// File: src/etr_ifs.sv
// Valid/ready channel interfaces for trace events and result items.
// Depends on etr_pkg for field widths.
`default_nettype none

interface etr_event_if;
  logic                        valid;
  logic                        ready;
  logic [etr_pkg::KIND_W-1:0]  kind;
  logic [etr_pkg::CLS_W-1:0]   event_id;
  logic [etr_pkg::TIME_W-1:0]  start_time;
  logic [etr_pkg::TIME_W-1:0]  end_time;
  logic [etr_pkg::FRAME_W-1:0] frame_tag;
  logic signed [etr_pkg::ARG_W-1:0] arg_a;
  logic signed [etr_pkg::ARG_W-1:0] arg_b;

  modport source (output valid, kind, event_id, start_time, end_time, frame_tag,
                  arg_a, arg_b, input ready);
  modport sink   (input valid, kind, event_id, start_time, end_time, frame_tag,
                  arg_a, arg_b, output ready);
endinterface

interface etr_result_if;
  logic                        valid;
  logic                        ready;
  logic [etr_pkg::CLS_W-1:0]   logged_event;
  logic [etr_pkg::TIME_W-1:0]  duration;
  logic [etr_pkg::FRAME_W-1:0] logged_frame;
  logic [etr_pkg::COUNT_W-1:0] class_hits;
  logic [etr_pkg::TIME_W-1:0]  event_total;
  logic [etr_pkg::TIME_W-1:0]  event_maximum;
  logic [etr_pkg::TIME_W-1:0]  maximum_start;
  logic [etr_pkg::COUNT_W-1:0] slow_count;
  logic                        is_slow;
  logic [etr_pkg::COUNT_W-1:0] ring_position;
  logic                        last;

  modport source (output valid, logged_event, duration, logged_frame, class_hits,
                  event_total, event_maximum, maximum_start, slow_count, is_slow,
                  ring_position, last, input ready);
  modport sink   (input valid, logged_event, duration, logged_frame, class_hits,
                  event_total, event_maximum, maximum_start, slow_count, is_slow,
                  ring_position, last, output ready);
endinterface

`default_nettype wire

// File: src/event_trace_recorder_with_stats.sv
// Event trace recorder with per-class statistics (top level).
// Channel evt takes trace events (record, mark, set frame, presentation);
// channel res gives one result per stored event, at most two per input,
// with last set on the final one. Both use valid/ready; a transfer happens
// on a rising edge with valid and ready high.
// A transfer loads the stage register, which then loads the result register.
// Throughput: one event per cycle while res is not stalled; a presentation
// that also stores a present gap holds evt while its second result goes
// through the class-statistics stage.
// Configuration (cfg_we, cfg_index, cfg_wdata) is to be written while idle;
// the block itself does not enforce this.
// Reset (rst, synchronous) clears enable, origin, counters, frame and present
// history and all class statistics; threshold returns to 500000. The rings
// need no clearing pass.
// When res is stalled the result register holds, the stage behind it holds,
// and evt ready drops; nothing is lost or repeated.
// Depends on etr_pkg, etr_ifs, etr_front, etr_stats, etr_ring.
`default_nettype none
`include "event_trace_recorder_with_stats_assert.svh"

module event_trace_recorder_with_stats #(
  parameter int unsigned RECENT_DEPTH  = etr_pkg::RECENT_DEPTH_DEF,
  parameter int unsigned SLOW_DEPTH    = etr_pkg::SLOW_DEPTH_DEF,
  parameter int unsigned EVENT_CLASSES = etr_pkg::EVENT_CLASSES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [etr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [etr_pkg::TIME_W-1:0]      cfg_wdata,
  etr_event_if.sink                       evt,
  etr_result_if.source                    res
);
  import etr_pkg::*;

  cfg_t     cfg;
  offer_t   offer_next;
  logic     advance;
  ring_wr_t ring_wr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable    <= 1'b0;
      cfg.origin    <= '0;
      cfg.threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRACE_ENABLE:   cfg.enable    <= cfg_wdata[0];
        REG_TIME_ORIGIN:    cfg.origin    <= cfg_wdata;
        REG_SLOW_THRESHOLD: cfg.threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  etr_front #(.EVENT_CLASSES(EVENT_CLASSES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .evt        (evt),
    .cfg        (cfg),
    .advance    (advance),
    .offer_next (offer_next)
  );

  etr_stats #(.EVENT_CLASSES(EVENT_CLASSES)) u_stats (
    .clk        (clk),
    .rst        (rst),
    .offer_next (offer_next),
    .threshold  (cfg.threshold),
    .advance    (advance),
    .ring_wr    (ring_wr),
    .res        (res)
  );

  etr_ring #(.DEPTH(RECENT_DEPTH)) u_recent (
    .clk   (clk),
    .rst   (rst),
    .we    (ring_wr.recent_we),
    .entry (ring_wr.entry)
  );

  etr_ring #(.DEPTH(SLOW_DEPTH)) u_slow (
    .clk   (clk),
    .rst   (rst),
    .we    (ring_wr.slow_we),
    .entry (ring_wr.entry)
  );

  // Checks
  `ETR_ASSERT_NEXT(a_pair, res.valid && res.ready && !res.last, res.valid, "no second result")
  `ETR_ASSERT_NOW(a_peak, res.valid, res.event_maximum <= res.event_total, "peak above total")
  `ETR_ASSERT_NOW(a_slow, res.valid && res.is_slow, res.slow_count != '0, "zero slow count")

endmodule

`default_nettype wire

// File: src/etr_front.sv
// Event front end: checks each trace event, keeps frame and present history,
// and issues up to two offers per event. Depends on etr_pkg and etr_ifs.
`default_nettype none

module etr_front #(
  parameter int unsigned EVENT_CLASSES = etr_pkg::EVENT_CLASSES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  etr_event_if.sink       evt,
  input  etr_pkg::cfg_t   cfg,
  input  logic            advance,
  output etr_pkg::offer_t offer_next
);
  import etr_pkg::*;

  logic [FRAME_W-1:0] current_frame;
  logic [TIME_W-1:0]  prev_present;
  logic [ARG_W-1:0]   prev_swap;
  offer_t             pend;

  kind_t              kind;
  logic               take;
  offer_t             first;
  offer_t             gap;
  logic [TIME_W-1:0]  first_end;
  logic               first_ok;
  logic               gap_ok;

  assign kind      = kind_t'(evt.kind);
  assign evt.ready = advance && !pend.valid;
  assign take      = evt.valid && evt.ready;

  // Primary offer: record, mark or present
  always_comb begin
    first       = '0;
    first_end   = (kind == KIND_MARK) ? evt.start_time : evt.end_time;
    first.cls   = (kind == KIND_PRESENT) ? PRESENT_CLASS : evt.event_id;
    first.start = evt.start_time;
    first.dur   = first_end - evt.start_time;
    first.frame = (kind == KIND_RECORD) ? evt.frame_tag : current_frame;
    first.a     = evt.arg_a;
    first.b     = evt.arg_b;
    first_ok    = cfg.enable && (kind != KIND_SET_FRAME)
                  && ({1'b0, first.cls} < (CLS_W+1)'(EVENT_CLASSES))
                  && (evt.start_time != '0) && (evt.start_time >= cfg.origin)
                  && (first_end >= evt.start_time);
  end

  // Present gap offer, from the previous present start to this one
  always_comb begin
    gap       = '0;
    gap.valid = 1'b1;
    gap.last  = 1'b1;
    gap.cls   = PRESENT_GAP_CLASS;
    gap.start = prev_present;
    gap.dur   = evt.start_time - prev_present;
    gap.frame = current_frame;
    gap.a     = '0;
    gap.b     = evt.arg_b;
    gap_ok    = cfg.enable && (kind == KIND_PRESENT) && (evt.arg_a == S_OK)
                && (prev_present != '0) && (prev_swap == evt.arg_b)
                && (prev_present >= cfg.origin) && (evt.start_time >= prev_present);
  end

  // Offer handed to the statistics stage
  always_comb begin
    offer_next = '0;
    if (pend.valid) begin
      offer_next = pend;
    end else if (take && first_ok) begin
      offer_next       = first;
      offer_next.valid = 1'b1;
      offer_next.last  = !gap_ok;
    end else if (take && gap_ok) begin
      offer_next = gap;
    end
  end

  // History and pending second offer
  always_ff @(posedge clk) begin
    if (rst) begin
      pend.valid    <= 1'b0;
      current_frame <= '0;
      prev_present  <= '0;
      prev_swap     <= '0;
    end else begin
      if (advance && pend.valid) begin
        pend.valid <= 1'b0;
      end
      if (take && first_ok && gap_ok) begin
        pend <= gap;
      end
      if (take && cfg.enable) begin
        case (kind)
          KIND_SET_FRAME: current_frame <= evt.frame_tag;
          KIND_PRESENT: begin
            if (evt.arg_a != S_OK) begin
              prev_present <= '0;
            end else begin
              prev_present <= evt.start_time;
              prev_swap    <= evt.arg_b;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: src/etr_stats.sv
// Per-class statistics stage: class memory read, update and result register.
// Depends on etr_pkg and etr_ifs.
`default_nettype none

module etr_stats #(
  parameter int unsigned EVENT_CLASSES = etr_pkg::EVENT_CLASSES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  etr_pkg::offer_t             offer_next,
  input  logic [etr_pkg::TIME_W-1:0]  threshold,
  output logic                        advance,
  output etr_pkg::ring_wr_t           ring_wr,
  etr_result_if.source                res
);
  import etr_pkg::*;

  localparam int unsigned CLS_AW = $clog2(EVENT_CLASSES);

  stats_t             stat_mem [EVENT_CLASSES];
  logic [EVENT_CLASSES-1:0] stat_valid;
  offer_t             stage;
  stats_t             stat_rd;
  logic               stat_rd_valid;
  logic               fwd_valid;
  logic [CLS_W-1:0]   fwd_cls;
  stats_t             fwd_stats;
  logic [COUNT_W-1:0] recent_written;

  logic               wr_en;
  logic [CLS_AW-1:0]  rd_idx;
  logic [CLS_AW-1:0]  wr_idx;
  stats_t             old_stats;
  stats_t             new_stats;
  logic [TIME_W:0]    sum_wide;
  logic               slow;

  assign advance = !res.valid || res.ready;
  assign wr_en   = advance && stage.valid;
  assign rd_idx  = offer_next.cls[CLS_AW-1:0];
  assign wr_idx  = stage.cls[CLS_AW-1:0];

  // Current class statistics: last write wins, unwritten classes read zero
  always_comb begin
    if (fwd_valid && (fwd_cls == stage.cls)) begin
      old_stats = fwd_stats;
    end else if (stat_rd_valid) begin
      old_stats = stat_rd;
    end else begin
      old_stats = '0;
    end
  end

  // Update: count, saturating total, peak, slow count
  always_comb begin
    new_stats       = old_stats;
    slow            = (stage.dur >= threshold);
    sum_wide        = {1'b0, old_stats.sum} + {1'b0, stage.dur};
    new_stats.count = old_stats.count + COUNT_W'(1);
    new_stats.sum   = sum_wide[TIME_W] ? '1 : sum_wide[TIME_W-1:0];
    if (stage.dur > old_stats.peak) begin
      new_stats.peak       = stage.dur;
      new_stats.peak_start = stage.start;
    end
    new_stats.slow_count = old_stats.slow_count + COUNT_W'(slow);
  end

  // Ring write request
  always_comb begin
    ring_wr.recent_we   = wr_en;
    ring_wr.slow_we     = wr_en && slow;
    ring_wr.entry.cls   = stage.cls;
    ring_wr.entry.start = stage.start;
    ring_wr.entry.len   = stage.dur;
    ring_wr.entry.frame = stage.frame;
    ring_wr.entry.a     = stage.a;
    ring_wr.entry.b     = stage.b;
  end

  // Class memory, registered read
  always_ff @(posedge clk) begin
    if (advance && offer_next.valid) begin
      stat_rd <= stat_mem[rd_idx];
    end
    if (wr_en) begin
      stat_mem[wr_idx] <= new_stats;
    end
  end

  // Control: stage, valid bits, forwarding, counters, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid    <= 1'b0;
      stat_valid     <= '0;
      stat_rd_valid  <= 1'b0;
      fwd_valid      <= 1'b0;
      recent_written <= '0;
      res.valid      <= 1'b0;
    end else begin
      if (advance) begin
        stage <= offer_next;
        if (offer_next.valid) begin
          stat_rd_valid <= stat_valid[rd_idx];
        end
      end
      if (wr_en) begin
        stat_valid[wr_idx] <= 1'b1;
        fwd_valid          <= 1'b1;
        recent_written     <= recent_written + COUNT_W'(1);
      end
      if (advance) begin
        res.valid <= stage.valid;
      end
    end
  end

  // Forwarding copy and result payload
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_cls           <= stage.cls;
      fwd_stats         <= new_stats;
      res.logged_event  <= stage.cls;
      res.duration      <= stage.dur;
      res.logged_frame  <= stage.frame;
      res.class_hits    <= new_stats.count;
      res.event_total   <= new_stats.sum;
      res.event_maximum <= new_stats.peak;
      res.maximum_start <= new_stats.peak_start;
      res.slow_count    <= new_stats.slow_count;
      res.is_slow       <= slow;
      res.ring_position <= recent_written;
      res.last          <= stage.last;
    end
  end

endmodule

`default_nettype wire

// File: src/etr_ring.sv
// Wrapping trace ring: write-only entry memory with its own write pointer.
// Depends on etr_pkg.
`default_nettype none

module etr_ring #(
  parameter int unsigned DEPTH = etr_pkg::RECENT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 we,
  input  etr_pkg::ring_entry_t entry
);
  import etr_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  ring_entry_t    mem [DEPTH];
  logic [AW-1:0]  wr_ptr;

  // Write pointer wraps at the ring depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
    end else if (we) begin
      wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_ptr] <= entry;
    end
  end

endmodule

`default_nettype wire
